>>> rtl/core/bbus_pkg.sv
// ---------------------------------------------------------------------------
// bbus_pkg
// Shared types and constants of the box-blur unsharp sharpener.
// ---------------------------------------------------------------------------
package bbus_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [15:0] HEIGHT_RESET = 16'd768;
    localparam logic [15:0] GAIN_RESET   = 16'd1024;

    // Reciprocals of 3 and 9 with their shifts; exact for 19-bit dividends.
    localparam logic [18:0] RECIP3 = 19'd349526;
    localparam logic [18:0] RECIP9 = 19'd466034;
    localparam int          SHIFT3 = 20;
    localparam int          SHIFT9 = 22;

    typedef struct packed {
        logic pass;
        logic mul9;
        logic eor;
        logic eof;
    } t_tag;

endpackage

>>> rtl/core/box_blur_unsharp_sharpen_top.sv
// ---------------------------------------------------------------------------
// box_blur_unsharp_sharpen_top
// Streaming 3x3 box-blur unsharp-mask sharpener for 8-bit pixels.
// ---------------------------------------------------------------------------
// Path: issue register, row-memory read, sharpener pipeline, then result queue.
// Throughput: one pixel per cycle while the queue has room; a row's last pixel
// holds input for its second column update; both share the single row-memory port.
// Reset: synchronous; counters, window and queue clear; row memories are not cleared.
module box_blur_unsharp_sharpen_top import bbus_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel_in
    input  logic [0:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // pixel_out
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser,   // end_of_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = (AW + 1 > 11) ? AW + 1 : 11;

    typedef struct packed {
        logic          valid;
        logic          pass;
        logic          wr;
        logic          emit;
        logic          use_nb;
        logic          use_above;
        logic          mul9;
        logic [AW-1:0] k;
        logic [9:0]    nb;
        logic [7:0]    q;
        logic          eor;
        logic          eof;
    } t_op;

    logic [10:0]        r_width;
    logic [15:0]        r_height;
    logic signed [15:0] r_gain;
    logic [AW-1:0]      r_col, n_col, r_drain, n_drain;
    logic [15:0]        r_row, n_row;
    logic [7:0]         r_win0, n_win0, r_win1, n_win1;
    t_op                r_opb, r_s1;
    t_op                op_a, op_b, iss, wop;
    logic [FIFO_AW:0]   r_pend;
    logic [17:0]        r_rd_cur;
    logic [9:0]         r_rd_above;
    logic [17:0]        r_mem_cur   [MAX_WIDTH];
    logic [9:0]         r_mem_above [MAX_WIDTH];

    logic [WW-1:0] w_eff, wp, col_nx, drain_nx;
    logic          passthru, action, s_acc, m_acc;
    logic          c_last, p_last, d_last, row_last;
    logic [7:0]    pix;
    logic [10:0]   pair, edge_sum;
    logic [9:0]    mid_sum;

    logic [11:0]        sum, pm;
    logic [7:0]         pix_s1;
    logic signed [12:0] delta;
    t_tag               tag_s1, sh_tag;
    logic               sh_valid;
    logic [7:0]         sh_pix;

    assign pready = 1'b1;

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {21'd0, r_width};
            REG_HEIGHT: prdata = {16'd0, r_height};
            REG_GAIN:   prdata = {16'd0, r_gain};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_gain   <= GAIN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[10:0];
                REG_HEIGHT: r_height <= pwdata[15:0];
                REG_GAIN:   r_gain   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign w_eff    = (WW'(r_width) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_width);
    assign wp       = (w_eff == '0) ? WW'(1) : w_eff;
    assign passthru = (w_eff < WW'(3)) || (r_height < 16'd3) || (r_gain == '0);
    assign action   = s_axis_tuser[0];
    assign pix      = s_axis_tdata;
    assign s_axis_tready = !r_opb.valid && (r_pend <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign col_nx   = WW'(r_col) + WW'(1);
    assign drain_nx = WW'(r_drain) + WW'(1);
    assign c_last   = col_nx >= w_eff;
    assign p_last   = col_nx >= wp;
    assign d_last   = drain_nx >= w_eff;
    assign row_last = ({1'b0, r_row} + 17'd1) >= {1'b0, r_height};
    assign pair     = {3'd0, r_win0} + {3'd0, pix};
    assign edge_sum = ((pair << 1) + pair + 11'd1) >> 1;
    assign mid_sum  = {2'd0, r_win1} + {2'd0, r_win0} + {2'd0, pix};

    always_comb begin
        wop           = '0;
        wop.valid     = 1'b1;
        wop.wr        = 1'b1;
        wop.emit      = (r_row != '0);
        wop.use_nb    = 1'b1;
        wop.use_above = (r_row > 16'd1);
        wop.mul9      = (r_row > 16'd1);
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_drain = r_drain;
        n_win0  = r_win0;
        n_win1  = r_win1;
        op_a    = '0;
        op_b    = '0;
        if (s_acc) begin
            if (passthru) begin
                if (!action) begin
                    op_a.valid = 1'b1;
                    op_a.pass  = 1'b1;
                    op_a.emit  = 1'b1;
                    op_a.q     = pix;
                    op_a.eor   = p_last;
                    op_a.eof   = p_last && row_last;
                    if (p_last) begin
                        n_col = '0;
                        n_row = row_last ? 16'd0 : r_row + 16'd1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end else if (r_row >= r_height) begin
                if (action) begin
                    op_a.valid     = 1'b1;
                    op_a.emit      = 1'b1;
                    op_a.use_above = 1'b1;
                    op_a.k         = r_drain;
                    op_a.eor       = d_last;
                    op_a.eof       = d_last;
                    if (d_last) begin
                        n_row   = '0;
                        n_col   = '0;
                        n_drain = '0;
                    end else begin
                        n_drain = r_drain + 1'b1;
                    end
                end
            end else if (!action) begin
                if (r_col == AW'(1)) begin
                    op_a    = wop;
                    op_a.k  = '0;
                    op_a.nb = edge_sum[9:0];
                    op_a.q  = r_win0;
                end else if (r_col >= AW'(2)) begin
                    op_a    = wop;
                    op_a.k  = r_col - 1'b1;
                    op_a.nb = mid_sum;
                    op_a.q  = r_win0;
                end
                if (c_last && (r_col != '0)) begin
                    op_b     = wop;
                    op_b.k   = r_col;
                    op_b.nb  = edge_sum[9:0];
                    op_b.q   = pix;
                    op_b.eor = 1'b1;
                end
                n_win1 = r_win0;
                n_win0 = pix;
                if (c_last) begin
                    n_col = '0;
                    n_row = r_row + 16'd1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    assign iss   = r_opb.valid ? r_opb : op_a;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
            r_win0  <= '0;
            r_win1  <= '0;
            r_opb   <= '0;
            r_s1    <= '0;
            r_pend  <= '0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_drain <= n_drain;
            r_win0  <= n_win0;
            r_win1  <= n_win1;
            r_opb   <= op_b;
            r_s1    <= iss;
            r_pend  <= r_pend + (FIFO_AW+1)'(iss.valid && iss.emit) - (FIFO_AW+1)'(m_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_cur   <= r_mem_cur[iss.k];
        r_rd_above <= r_mem_above[iss.k];
        if (r_s1.valid && r_s1.wr) begin
            r_mem_cur[r_s1.k] <= {r_s1.q, r_s1.nb};
            if (r_s1.emit) begin
                r_mem_above[r_s1.k] <= r_rd_cur[9:0];
            end
        end
    end

    always_comb begin
        sum = {2'd0, r_rd_cur[9:0]}
            + (r_s1.use_above ? {2'd0, r_rd_above} : 12'd0)
            + (r_s1.use_nb ? {2'd0, r_s1.nb} : 12'd0);
        pix_s1 = r_s1.pass ? r_s1.q : r_rd_cur[17:10];
        pm = r_s1.mul9 ? (({4'd0, pix_s1} << 3) + {4'd0, pix_s1})
                       : (({4'd0, pix_s1} << 2) + ({4'd0, pix_s1} << 1));
        delta = $signed({1'b0, pm}) - $signed({1'b0, sum});
        tag_s1.pass = r_s1.pass;
        tag_s1.mul9 = r_s1.mul9;
        tag_s1.eor  = r_s1.eor;
        tag_s1.eof  = r_s1.eof;
    end

    bbus_sharpen u_sharpen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_gain),
        .i_valid (r_s1.valid && r_s1.emit),
        .i_delta (delta),
        .i_pix   (pix_s1),
        .i_tag   (tag_s1),
        .o_valid (sh_valid),
        .o_pix   (sh_pix),
        .o_tag   (sh_tag)
    );

    bbus_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sh_valid),
        .i_data  ({sh_tag.eof, sh_tag.eor, sh_pix}),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  ({m_axis_tuser[0], m_axis_tlast, m_axis_tdata})
    );

endmodule

>>> rtl/core/bbus_sharpen.sv
// ---------------------------------------------------------------------------
// bbus_sharpen
// Pipelined gain multiply, constant division and clamp of the sharpener.
// ---------------------------------------------------------------------------
module bbus_sharpen import bbus_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [15:0] i_gain,
    input  logic               i_valid,
    input  logic signed [12:0] i_delta,
    input  logic [7:0]         i_pix,
    input  t_tag               i_tag,
    output logic               o_valid,
    output logic [7:0]         o_pix,
    output t_tag               o_tag
);

    logic               r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic signed [12:0] r_a_delta;
    logic [7:0]         r_a_pix, r_b_pix, r_c_pix, r_d_pix;
    t_tag               r_a_tag, r_b_tag, r_c_tag, r_d_tag;
    logic signed [28:0] r_b_prod;
    logic [37:0]        r_c_q;
    logic               r_c_neg;

    logic [28:0] mag;
    logic [28:0] shifted;
    logic [18:0] dividend;
    logic [37:0] q_shift;
    logic [15:0] quo;
    logic signed [17:0] val;
    logic [7:0]  clamped;

    always_comb begin
        mag      = r_b_prod[28] ? 29'(-r_b_prod) : 29'(r_b_prod);
        shifted  = r_b_tag.mul9 ? (mag >> 8) : (mag >> 9);
        dividend = shifted[18:0];
        q_shift  = r_c_tag.mul9 ? (r_c_q >> SHIFT9) : (r_c_q >> SHIFT3);
        quo      = q_shift[15:0];
        val      = $signed({10'd0, r_c_pix})
                 + (r_c_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));
        if (val < 0) begin
            clamped = 8'd0;
        end else if (val > 18'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = val[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
        r_a_delta <= i_delta;
        r_a_pix   <= i_pix;
        r_a_tag   <= i_tag;
        r_b_prod  <= 29'(i_gain * r_a_delta);
        r_b_pix   <= r_a_pix;
        r_b_tag   <= r_a_tag;
        r_c_q     <= {19'd0, dividend} * {19'd0, (r_b_tag.mul9 ? RECIP9 : RECIP3)};
        r_c_neg   <= r_b_prod[28];
        r_c_pix   <= r_b_pix;
        r_c_tag   <= r_b_tag;
        r_d_pix   <= r_c_tag.pass ? r_c_pix : clamped;
        r_d_tag   <= r_c_tag;
    end

    assign o_valid = r_d_valid;
    assign o_pix   = r_d_pix;
    assign o_tag   = r_d_tag;

endmodule

>>> rtl/core/bbus_fifo.sv
// ---------------------------------------------------------------------------
// bbus_fifo
// Result queue between the sharpening pipeline and the output stream.
// ---------------------------------------------------------------------------
module bbus_fifo import bbus_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [9:0] i_data,
    input  logic       i_pop,
    output logic       o_valid,
    output logic [9:0] o_data
);

    logic [9:0]         r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (FIFO_AW+1)'(i_push) - (FIFO_AW+1)'(pop);
        end
    end

endmodule

>>> sim/tb_box_blur_unsharp_sharpen_top.sv
// ---------------------------------------------------------------------------
// tb_box_blur_unsharp_sharpen_top
// Self-checking testbench of the box-blur unsharp sharpener. Frames of random
// pixels are streamed under several register settings. A scoreboard class
// predicts every sharpened pixel with its row and frame flags. Both stream
// sides idle at random, and the output side holds off long enough to stall
// the input.
// ---------------------------------------------------------------------------
module tb_box_blur_unsharp_sharpen_top import bbus_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit [7:0] pix;
        bit       eor;
        bit       eof;
    } t_sharp_px;

    class sharpen_scoreboard;
        t_sharp_px   pending[$];
        int          errors;
        int          n_in;
        int          n_out;
        bit [7:0]    row_pix[1024];
        bit [9:0]    blur_up[1024];
        bit [9:0]    blur_mid[1024];
        bit [7:0]    win0;
        bit [7:0]    win1;
        int unsigned rows;
        int unsigned cols;
        int unsigned drain;
        bit [10:0]   width;
        bit [15:0]   height;
        bit [15:0]   gain;

        function new();
            width  = WIDTH_RESET;
            height = HEIGHT_RESET;
            gain   = GAIN_RESET;
        endfunction

        function void set_reg(logic [1:0] idx, bit [31:0] v);
            case (idx)
                REG_WIDTH:  width  = v[10:0];
                REG_HEIGHT: height = v[15:0];
                REG_GAIN:   gain   = v[15:0];
                default: ;
            endcase
        endfunction

        function int weff();
            return (width > 1024) ? 1024 : int'(width);
        endfunction

        function bit [7:0] sharpen(int pix, int sum, int mul);
            int g = $signed(gain);
            int val;
            val = pix + (g * (pix * mul - sum)) / (mul * 256);
            if (val < 0) val = 0;
            if (val > 255) val = 255;
            return val[7:0];
        endfunction

        function void push(bit [7:0] pix, bit eor, bit eof);
            t_sharp_px r;
            r.pix = pix;
            r.eor = eor;
            r.eof = eof;
            pending.push_back(r);
        endfunction

        function void col_done(int k, int nb, bit [7:0] q, bit eor);
            if (rows != 0) begin
                if (rows == 1)
                    push(sharpen(row_pix[k], blur_mid[k] + nb, 6), eor, 1'b0);
                else
                    push(sharpen(row_pix[k], blur_up[k] + blur_mid[k] + nb, 9), eor, 1'b0);
                blur_up[k] = blur_mid[k];
            end
            blur_mid[k] = nb[9:0];
            row_pix[k]  = q;
        endfunction

        function void note_input(bit act, bit [7:0] p);
            int w = weff();
            int wp;
            bit eor;
            bit eof;
            bit last;
            n_in++;
            if (w < 3 || height < 3 || gain == 0) begin
                wp = (w == 0) ? 1 : w;
                if (act) return;
                eor = (cols + 1 >= wp);
                eof = eor && (rows + 1 >= height);
                push(p, eor, eof);
                if (eor) begin
                    cols = 0;
                    rows = eof ? 0 : ((rows + 1) & 16'hFFFF);
                end else begin
                    cols++;
                end
                return;
            end
            if (rows >= height) begin
                if (!act || drain >= 1024) return;
                last = (drain + 1 >= w);
                push(sharpen(row_pix[drain], blur_up[drain] + blur_mid[drain], 6), last, last);
                if (last) begin
                    rows  = 0;
                    cols  = 0;
                    drain = 0;
                end else begin
                    drain++;
                end
                return;
            end
            if (act) return;
            last = (cols + 1 >= w);
            if (cols == 1)
                col_done(0, (3 * (win0 + p) + 1) >> 1, win0, 1'b0);
            else if (cols >= 2)
                col_done(cols - 1, win1 + win0 + p, win0, 1'b0);
            if (last && cols >= 1)
                col_done(cols, (3 * (win0 + p) + 1) >> 1, p, 1'b1);
            win1 = win0;
            win0 = p;
            if (last) begin
                cols = 0;
                rows = (rows + 1) & 16'hFFFF;
            end else begin
                cols++;
            end
        endfunction

        function void check_result(bit [7:0] pix, bit eor, bit eof);
            t_sharp_px e;
            n_out++;
            if (pending.size() == 0) begin
                $error("unexpected transfer: pixel_out %0d", pix);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (pix !== e.pix) begin
                $error("pixel_out expected %0d actual %0d", e.pix, pix);
                errors++;
            end
            if (eor !== e.eor) begin
                $error("end_of_row expected %0d actual %0d", e.eor, eor);
                errors++;
            end
            if (eof !== e.eof) begin
                $error("end_of_frame expected %0d actual %0d", e.eof, eof);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // pixel_in
    logic [0:0]  s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // pixel_out
    logic        m_axis_tlast;   // end_of_row
    logic [0:0]  m_axis_tuser;   // end_of_frame
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sharpen_scoreboard sb;
    int  burst_left;
    int  frames;
    bit  hold_req;

    box_blur_unsharp_sharpen_top i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // Output side: a changing stall pattern plus long hold-offs on request.
    initial begin
        int hold_cnt;
        int mode;
        int phase;
        hold_cnt = 0;
        mode = 0;
        phase = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
            if (++phase >= 64) begin
                phase = 0;
                mode = $urandom_range(0, 2);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 200;
                m_axis_tready <= 1'b0;
            end else if (mode == 0) begin
                m_axis_tready <= 1'b1;
            end else if (mode == 1) begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end else begin
                m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic apb_write(logic [1:0] idx, bit [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic send_item(bit act, bit [7:0] p);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(act, p);
        if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic bit [7:0] rand_pix();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One whole frame under the given settings; noise items are ignored by the block.
    task automatic run_frame(int w, int h, int g, bit noise);
        int wp;
        wait_idle();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_GAIN, g & 16'hFFFF);
        wp = (sb.weff() == 0) ? 1 : sb.weff();
        if (sb.weff() >= 32 || $urandom_range(0, 9) == 0) hold_req = 1'b1;
        if (sb.weff() < 3 || h < 3 || g == 0) begin
            for (int i = 0; i < wp * ((h == 0) ? 1 : h); i++) begin
                if (noise && $urandom_range(0, 15) == 0) send_item(1'b1, rand_pix());
                send_item(1'b0, rand_pix());
            end
        end else begin
            for (int i = 0; i < wp * h; i++) begin
                if (noise && $urandom_range(0, 15) == 0) send_item(1'b1, rand_pix());
                send_item(1'b0, rand_pix());
            end
            while (sb.rows != 0) begin
                if (noise && $urandom_range(0, 7) == 0) send_item(1'b0, rand_pix());
                send_item(1'b1, rand_pix());
            end
        end
        frames++;
    endtask

    initial begin
        sb = new();
        burst_left = 8;
        frames = 0;
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register extremes that are not streamed through.
        apb_write(REG_HEIGHT, 16'hFFFF);
        apb_write(REG_WIDTH, 2047);
        apb_write(REG_WIDTH, 1);

        // Directed settings: smallest frames, gain extremes, passthrough cases.
        run_frame(3, 3, 1024, 1'b0);
        run_frame(3, 3, 32767, 1'b0);
        run_frame(4, 3, -32768, 1'b0);
        run_frame(1, 1, 1024, 1'b1);
        run_frame(0, 2, 1024, 1'b1);
        run_frame(2, 3, 1024, 1'b1);
        run_frame(5, 2, 1024, 1'b1);
        run_frame(4, 3, 0, 1'b1);
        run_frame(60, 3, 700, 1'b0);

        while (sb.n_in < 1000) begin
            if ($urandom_range(0, 7) == 0)
                run_frame($urandom_range(0, 4), $urandom_range(0, 4),
                          $urandom_range(0, 3) == 0 ? 0 : 512, 1'b1);
            else
                run_frame($urandom_range(3, 24), $urandom_range(3, 7),
                          $urandom_range(0, 65535) - 32768, 1'b1);
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected pixels never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Streamed %0d transfers in %0d frames, checked %0d output pixels.",
                 sb.n_in, frames, sb.n_out);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
